/* sv/qvr_pkg.sv */
// shared constants for the quaternion vector rotation block
`default_nettype none
package qvr_pkg;
   localparam int QUAT_FRAC_BITS_DEF = 16;
   localparam int VEC_WIDTH_DEF      = 32;
   localparam int CSR_WIDTH          = 32;
   localparam logic [CSR_WIDTH-1:0] NORM_EPSILON_RESET = 32'd1;
endpackage
`default_nettype wire

/* sv/qvr_div_lane.sv */
// one coordinate: rounded division of the numerator by the norm, then saturation
`default_nettype none
module qvr_div_lane #(
   parameter int QUAT_FRAC_BITS = 16,
   parameter int VEC_WIDTH      = 32
) (
   input  wire logic clock,
   input  wire logic en,
   input  wire logic signed [2*(QUAT_FRAC_BITS+2)+VEC_WIDTH+3:0] num,
   input  wire logic [2*(QUAT_FRAC_BITS+2):0] div,
   output logic [VEC_WIDTH-1:0] rot,
   output logic sat
);
   import qvr_pkg::*;

   localparam int QW   = QUAT_FRAC_BITS + 2;
   localparam int NUMW = 2*QW + VEC_WIDTH + 4;
   localparam int NW   = 2*QW + 1;
   localparam int AW   = NUMW + 2;
   localparam int DW   = NW + 1;
   localparam int XW   = (AW > DW + VEC_WIDTH) ? AW : DW + VEC_WIDTH;

   logic [NUMW-1:0] mag;
   logic [AW-1:0]   a_val;
   logic [DW-1:0]   dd;
   logic            ovf;

   logic [DW-1:0]        rem_ff [VEC_WIDTH+1];
   logic [VEC_WIDTH-1:0] alo_ff [VEC_WIDTH+1];
   logic [VEC_WIDTH-1:0] q_ff   [VEC_WIDTH+1];
   logic [DW-1:0]        dd_ff  [VEC_WIDTH+1];
   logic                 neg_ff [VEC_WIDTH+1];
   logic                 ovf_ff [VEC_WIDTH+1];

   logic [VEC_WIDTH-1:0] rot_in;
   logic                 sat_in;
   logic [VEC_WIDTH-1:0] rot_ff;
   logic                 sat_ff;

   // 2|num| + d over 2d gives round half away from zero
   always_comb begin
      mag   = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
      a_val = {1'b0, mag, 1'b0} + AW'(div);
      dd    = {div, 1'b0};
      ovf   = XW'(a_val) >= (XW'(dd) << VEC_WIDTH);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= DW'(a_val >> VEC_WIDTH);
         alo_ff[0] <= a_val[VEC_WIDTH-1:0];
         q_ff[0]   <= '0;
         dd_ff[0]  <= dd;
         neg_ff[0] <= num[NUMW-1];
         ovf_ff[0] <= ovf;
      end
   end

   // one quotient bit per stage
   for (genvar i = 0; i < VEC_WIDTH; i++) begin : g_step
      logic [DW:0] t;
      logic        ge;
      always_comb begin
         t  = {rem_ff[i], alo_ff[i][VEC_WIDTH-1]};
         ge = t >= {1'b0, dd_ff[i]};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1] <= ge ? DW'(t - {1'b0, dd_ff[i]}) : DW'(t);
            alo_ff[i+1] <= alo_ff[i] << 1;
            q_ff[i+1]   <= {q_ff[i][VEC_WIDTH-2:0], ge};
            dd_ff[i+1]  <= dd_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            ovf_ff[i+1] <= ovf_ff[i];
         end
      end
   end

   always_comb begin
      if (neg_ff[VEC_WIDTH]) begin
         sat_in = ovf_ff[VEC_WIDTH] ||
                  (q_ff[VEC_WIDTH][VEC_WIDTH-1] && (|q_ff[VEC_WIDTH][VEC_WIDTH-2:0]));
         rot_in = sat_in ? {1'b1, {(VEC_WIDTH-1){1'b0}}} : VEC_WIDTH'(-q_ff[VEC_WIDTH]);
      end else begin
         sat_in = ovf_ff[VEC_WIDTH] || q_ff[VEC_WIDTH][VEC_WIDTH-1];
         rot_in = sat_in ? {1'b0, {(VEC_WIDTH-1){1'b1}}} : q_ff[VEC_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rot_ff <= rot_in;
         sat_ff <= sat_in;
      end
   end

   assign rot = rot_ff;
   assign sat = sat_ff;
endmodule
`default_nettype wire

/* sv/quaternion_vector_rotate.sv */
// top level: rotation of a vector by q (0,v) q^-1 in fixed point
//
//   port group   dir  contents
//   req_*        in   quaternion (w,x,y,z) and vector (x,y,z)
//   rsp_*        out  rotated vector and degenerate flag
//   csr_*        in   norm_epsilon write
//
// one item enters per cycle while the output is not stalled; a bit-per-stage divider
// brings each coordinate back by the squared norm
// the whole pipeline holds while a result waits and rsp_ready is low
// reset clears the stage valid bits and sets norm_epsilon to 1
`default_nettype none
module quaternion_vector_rotate #(
   parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF,
   parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  wire logic signed [QUAT_FRAC_BITS+1:0] req_quat_w,
   input  wire logic signed [QUAT_FRAC_BITS+1:0] req_quat_x,
   input  wire logic signed [QUAT_FRAC_BITS+1:0] req_quat_y,
   input  wire logic signed [QUAT_FRAC_BITS+1:0] req_quat_z,
   input  wire logic signed [VEC_WIDTH-1:0] req_vec_x,
   input  wire logic signed [VEC_WIDTH-1:0] req_vec_y,
   input  wire logic signed [VEC_WIDTH-1:0] req_vec_z,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output logic signed [VEC_WIDTH-1:0] rsp_rot_x,
   output logic signed [VEC_WIDTH-1:0] rsp_rot_y,
   output logic signed [VEC_WIDTH-1:0] rsp_rot_z,
   output logic      rsp_degenerate,
   input  wire logic csr_valid,
   output logic      csr_ready,
   input  wire logic [qvr_pkg::CSR_WIDTH-1:0] csr_norm_epsilon
);
   import qvr_pkg::*;

   localparam int QW    = QUAT_FRAC_BITS + 2;
   localparam int VW    = VEC_WIDTH;
   localparam int PW    = QW + VW;
   localparam int SQW   = 2*QW;
   localparam int NW    = 2*QW + 1;
   localparam int SW    = 2*QW + 1;
   localparam int CW    = PW + 1;
   localparam int TW    = QW + CW;
   localparam int NUMW  = 2*QW + VW + 4;
   localparam int EW    = (NW > CSR_WIDTH) ? NW : CSR_WIDTH;
   localparam int DEPTH = VW + 6;

   logic en;
   logic [DEPTH-1:0] vld_ff;
   logic [CSR_WIDTH-1:0] eps_ff;

   logic signed [QW-1:0] u_in [3];
   logic signed [VW-1:0] v_in [3];

   // stage 1: products
   logic signed [SQW-1:0] pww_ff, pxx_ff, pyy_ff, pzz_ff;
   logic signed [PW-1:0]  pa_ff [3];
   logic signed [PW-1:0]  pb_ff [3];
   logic signed [PW-1:0]  puv_ff [3];
   logic signed [PW-1:0]  pwv_ff [3];
   logic signed [QW-1:0]  w1_ff;
   logic signed [QW-1:0]  u1_ff [3];
   logic signed [VW-1:0]  v1_ff [3];

   // stage 2: norm, scalar terms, cross and dot
   logic [NW-1:0]         n_in, n_ff;
   logic signed [SW-1:0]  s_in, s_ff;
   logic signed [CW-1:0]  cr_in [3];
   logic signed [CW-1:0]  cr_ff [3];
   logic signed [CW-1:0]  dot_in, dot_ff;
   logic signed [PW-1:0]  wv2_ff [3];
   logic signed [QW-1:0]  w2_ff;
   logic signed [QW-1:0]  u2_ff [3];
   logic signed [VW-1:0]  v2_ff [3];
   logic                  iden_in, iden2_ff;

   // stage 3: second products
   logic signed [SW+VW-1:0] tsv_ff [3];
   logic signed [TW-1:0]    tdu_ff [3];
   logic signed [TW-1:0]    twc_ff [3];
   logic signed [NUMW-1:0]  nid_ff [3];
   logic [NW-1:0]           d_in, d3_ff;
   logic                    iden3_ff;

   // stage 4: numerators
   logic signed [NUMW-1:0] num_in [3];
   logic signed [NUMW-1:0] num_ff [3];
   logic [NW-1:0]          d4_ff;
   logic                   iden4_ff;

   logic [VW+1:0] degd_ff;
   logic [VW-1:0] rot_out [3];
   logic [2:0]    sat_out;

   assign en        = rsp_ready || !vld_ff[DEPTH-1];
   assign req_ready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= NORM_EPSILON_RESET;
      end else if (csr_valid && csr_ready) begin
         eps_ff <= csr_norm_epsilon;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   always_comb begin
      u_in[0] = req_quat_x;
      u_in[1] = req_quat_y;
      u_in[2] = req_quat_z;
      v_in[0] = req_vec_x;
      v_in[1] = req_vec_y;
      v_in[2] = req_vec_z;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pww_ff <= req_quat_w * req_quat_w;
         pxx_ff <= req_quat_x * req_quat_x;
         pyy_ff <= req_quat_y * req_quat_y;
         pzz_ff <= req_quat_z * req_quat_z;
         w1_ff  <= req_quat_w;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_s1
      always_ff @(posedge clock) begin
         if (en) begin
            pa_ff[i]  <= u_in[(i+1)%3] * v_in[(i+2)%3];
            pb_ff[i]  <= u_in[(i+2)%3] * v_in[(i+1)%3];
            puv_ff[i] <= u_in[i] * v_in[i];
            pwv_ff[i] <= req_quat_w * v_in[i];
            u1_ff[i]  <= u_in[i];
            v1_ff[i]  <= v_in[i];
         end
      end
   end

   always_comb begin
      n_in = NW'($unsigned(pww_ff)) + NW'($unsigned(pxx_ff))
           + NW'($unsigned(pyy_ff)) + NW'($unsigned(pzz_ff));
      s_in = SW'(pww_ff) - (SW'(pxx_ff) + SW'(pyy_ff) + SW'(pzz_ff));
      dot_in = CW'(puv_ff[0]) + CW'(puv_ff[1]) + CW'(puv_ff[2]);
      for (int i = 0; i < 3; i++) begin
         cr_in[i] = CW'(pa_ff[i]) - CW'(pb_ff[i]);
      end
      // tiny or zero norm falls back to the identity inverse
      iden_in = (EW'(n_in) < EW'(eps_ff)) || (n_in == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff     <= n_in;
         s_ff     <= s_in;
         dot_ff   <= dot_in;
         w2_ff    <= w1_ff;
         iden2_ff <= iden_in;
         for (int i = 0; i < 3; i++) begin
            cr_ff[i]  <= cr_in[i];
            wv2_ff[i] <= pwv_ff[i];
            u2_ff[i]  <= u1_ff[i];
            v2_ff[i]  <= v1_ff[i];
         end
      end
   end

   assign d_in = iden2_ff ? ({{(NW-1){1'b0}}, 1'b1} << QUAT_FRAC_BITS) : n_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         d3_ff    <= d_in;
         iden3_ff <= iden2_ff;
         for (int i = 0; i < 3; i++) begin
            tsv_ff[i] <= s_ff * v2_ff[i];
            tdu_ff[i] <= dot_ff * u2_ff[i];
            twc_ff[i] <= w2_ff * cr_ff[i];
            nid_ff[i] <= NUMW'(wv2_ff[i]) + NUMW'(cr_ff[i]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = iden3_ff ? nid_ff[i]
                   : NUMW'(tsv_ff[i]) + (NUMW'(tdu_ff[i]) <<< 1)
                     + (NUMW'(twc_ff[i]) <<< 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d4_ff    <= d3_ff;
         iden4_ff <= iden3_ff;
         for (int i = 0; i < 3; i++) begin
            num_ff[i] <= num_in[i];
         end
         degd_ff  <= {degd_ff[VW:0], iden4_ff};
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      qvr_div_lane #(
         .QUAT_FRAC_BITS(QUAT_FRAC_BITS),
         .VEC_WIDTH     (VEC_WIDTH)
      ) u_lane (
         .clock(clock),
         .en   (en),
         .num  (num_ff[i]),
         .div  (d4_ff),
         .rot  (rot_out[i]),
         .sat  (sat_out[i])
      );
   end

   assign rsp_valid      = vld_ff[DEPTH-1];
   assign rsp_rot_x      = $signed(rot_out[0]);
   assign rsp_rot_y      = $signed(rot_out[1]);
   assign rsp_rot_z      = $signed(rot_out[2]);
   assign rsp_degenerate = degd_ff[VW+1] | (|sat_out);

`ifndef NO_ASSERTIONS
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

   a_transfer_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted transfer lost at first stage");

   a_stall_holds_valids: assert property (@(posedge clock) disable iff (reset)
      !en |=> vld_ff == $past(vld_ff))
      else $error("pipeline valids moved during stall");
`endif
endmodule
`default_nettype wire
